[src/mdsl_pkg.sv]
package mdsl_pkg;

  localparam int MOTOR_COUNT_DEF = 4;
  localparam int FRAC_BITS       = 40;
  localparam int DUTY_W          = 15;
  localparam int PCT_W           = 7;
  localparam int NUM_W           = 22;
  localparam int RECIP_SHIFT     = 29;
  localparam int RECIP_W         = 23;

  localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
  localparam logic [DUTY_W-1:0]  FULL_SCALE = 15'd25600;
  localparam logic [DUTY_W-1:0]  SLEW_STEP  = 15'd2560;
  localparam logic [RECIP_W-1:0] RECIP_K    = 23'd5368710;

  typedef logic [DUTY_W-1:0] duty_t;
  typedef duty_t curve_tab_t [0:127];

  typedef struct packed {
    logic [1:0]       motor;
    logic             test_mode;
    logic [PCT_W-1:0] requested_duty;
    logic [PCT_W-1:0] test_duty;
    logic [PCT_W-1:0] range_low;
    logic [PCT_W-1:0] range_high;
  } in_word_t;

  typedef struct packed {
    logic [1:0] motor_out;
    duty_t      drive_duty;
  } out_word_t;

  typedef struct packed {
    logic [1:0]       motor;
    logic             direct;
    duty_t            direct_duty;
    logic [NUM_W-1:0] num;
  } mid_word_t;

  function automatic curve_tab_t build_curve();
    curve_tab_t  tab;
    logic [63:0] p;
    logic [63:0] v;
    tab = '{default: '0};
    p = 64'd1 << FRAC_BITS;
    for (int d = 1; d < 100; d++) begin
      p = (p * 64'd41 + 64'd20) / 64'd40;
      v = (64'd8 * p + (64'd5 << FRAC_BITS) + (64'd1 << 31)) >> 32;
      tab[d] = v[DUTY_W-1:0];
    end
    return tab;
  endfunction

  localparam curve_tab_t CURVE_TAB = build_curve();

  function automatic logic [PCT_W-1:0] pct_sat(input logic [PCT_W-1:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

[src/mdsl_map.sv]
module mdsl_map (
  input  mdsl_pkg::in_word_t  in_word,
  input  logic                curve_enable,
  output mdsl_pkg::mid_word_t mid_word
);
  import mdsl_pkg::*;

  logic [PCT_W-1:0]  req;
  logic [PCT_W-1:0]  tst;
  logic [PCT_W-1:0]  lo;
  logic [PCT_W-1:0]  hi;
  duty_t             q;
  logic signed [7:0] span;
  logic signed [23:0] prod;
  logic [NUM_W-1:0]  base;
  logic signed [24:0] sum;

  always_comb begin
    req  = pct_sat(in_word.requested_duty);
    tst  = pct_sat(in_word.test_duty);
    lo   = pct_sat(in_word.range_low);
    hi   = pct_sat(in_word.range_high);
    if (curve_enable && req != PCT_MAX) begin
      q = CURVE_TAB[req];
    end else begin
      q = {req, 8'd0};
    end
    span = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod = span * $signed({1'b0, q});
    base = NUM_W'(lo) * NUM_W'(FULL_SCALE);
    sum  = $signed({3'b000, base}) + $signed({prod[23], prod});

    mid_word.motor       = in_word.motor;
    mid_word.direct      = in_word.test_mode || (req == '0);
    mid_word.direct_duty = in_word.test_mode ? {tst, 8'd0} : '0;
    mid_word.num         = sum[NUM_W-1:0];
  end

endmodule

[src/motor_duty_slew_limiter_top.sv]
// pipeline: s1 holds the input word, s2 the mapped word, out_word_r the slewed result word
// throughput: one word per cycle while out_stall is low, per-channel duty read and written in the last stage
// each stage holds its word while the next one stalls, so under output stall input is taken only while a stage is empty
// reset: synchronous active-low rst_n clears valids, curve_enable and all channel duties
module motor_duty_slew_limiter_top #(
  parameter int MOTOR_COUNT = mdsl_pkg::MOTOR_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mdsl_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mdsl_pkg::out_word_t  out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import mdsl_pkg::*;

  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  logic       curve_enable_r;
  logic       s1_valid_r;
  in_word_t   s1_word_r;
  logic       s2_valid_r;
  mid_word_t  s2_word_r;
  mid_word_t  s2_word_nxt;
  logic       out_valid_r;
  out_word_t  out_word_r;
  out_word_t  out_word_nxt;
  duty_t      applied_duty_r [MOTOR_COUNT];

  logic       out_en;
  logic       s2_en;
  logic       s1_en;

  logic [IDX_W+1:0]     motor_ext;
  logic [IDX_W-1:0]     idx;
  logic                 motor_ok;
  duty_t                cur;
  logic [44:0]          recip_prod;
  logic [15:0]          target_raw;
  duty_t                target;
  logic signed [16:0]   delta;
  duty_t                ramped;
  duty_t                result;

  assign out_en    = !out_valid_r || !out_stall;
  assign s2_en     = !s2_valid_r || out_en;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_stall  = !s1_en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  mdsl_map u_map (
    .in_word      (s1_word_r),
    .curve_enable (curve_enable_r),
    .mid_word     (s2_word_nxt)
  );

  // slew stage
  always_comb begin
    motor_ext  = {{IDX_W{1'b0}}, s2_word_r.motor};
    idx        = motor_ext[IDX_W-1:0];
    motor_ok   = motor_ext < (IDX_W+2)'(MOTOR_COUNT);
    cur        = motor_ok ? applied_duty_r[idx] : '0;
    recip_prod = 45'(s2_word_r.num) * 45'(RECIP_K);
    target_raw = recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
    target     = (target_raw > 16'(FULL_SCALE)) ? FULL_SCALE : target_raw[DUTY_W-1:0];
    delta      = $signed({2'b00, target}) - $signed({2'b00, cur});
    if (delta > $signed({2'b00, SLEW_STEP})) begin
      ramped = cur + SLEW_STEP;
    end else if (delta < -$signed({2'b00, SLEW_STEP})) begin
      ramped = cur - SLEW_STEP;
    end else begin
      ramped = target;
    end
    result = s2_word_r.direct ? s2_word_r.direct_duty : ramped;
    out_word_nxt.motor_out  = s2_word_r.motor;
    out_word_nxt.drive_duty = motor_ok ? result : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_enable_r <= 1'b0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        applied_duty_r[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        curve_enable_r <= cfg_data;
      end
      if (s1_en) begin
        s1_valid_r <= in_valid;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_en) begin
        out_valid_r <= s2_valid_r;
      end
      if (out_en && s2_valid_r && motor_ok) begin
        applied_duty_r[idx] <= result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_word_r <= in_word;
    end
    if (s2_en && s1_valid_r) begin
      s2_word_r <= s2_word_nxt;
    end
    if (out_en && s2_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

[verif/motor_duty_slew_limiter_top_tb.sv]
`timescale 1ns / 100ps

module motor_duty_slew_limiter_top_tb;
  import mdsl_pkg::*;

  localparam int  MOTORS       = MOTOR_COUNT_DEF;
  localparam int  DUTY_FULL    = 25600;
  localparam int  DUTY_RAMP    = 2560;
  localparam int  PCT_CAP      = 100;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  RX_HOLD_LEN  = 150;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  logic      tx_hold   = 1'b0;
  logic      rx_hold   = 1'b0;
  logic      no_idle   = 1'b0;

  in_word_t  pend_words[$];
  out_word_t duty_expect_q[$];
  longint    duty_curve[0:99];
  longint    chan_duty[0:MOTORS-1] = '{default: 0};
  logic      curve_on  = 1'b0;
  int        in_gap    = 0;
  int        out_wait  = 0;
  int        err_count = 0;
  int        words_sent    = 0;
  int        words_checked = 0;
  int        cfg_writes    = 0;
  logic [PCT_W-1:0] keep_req[0:3] = '{default: '0};
  logic [PCT_W-1:0] keep_lo[0:3]  = '{default: '0};
  logic [PCT_W-1:0] keep_hi[0:3]  = '{default: 7'd100};

  motor_duty_slew_limiter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin : curve_init
    longint unsigned p;
    p = 64'd1 << 40;
    duty_curve[0] = 0;
    for (int d = 1; d < 100; d++) begin
      p = (p * 64'd41 + 64'd20) / 64'd40;
      duty_curve[d] = longint'((64'd8 * p + (64'd5 << 40) + (64'd1 << 31)) >> 32);
    end
  end

  function automatic longint clip_pct(input logic [PCT_W-1:0] v);
    return (v > PCT_CAP) ? PCT_CAP : longint'(v);
  endfunction

  // expected duty for one tick, advances the per-channel applied duty
  function automatic out_word_t predict_duty(input in_word_t w);
    out_word_t r;
    longint    req, tst, lo, hi, q, num, tgt, delta;
    int        ch;
    req = clip_pct(w.requested_duty);
    tst = clip_pct(w.test_duty);
    lo  = clip_pct(w.range_low);
    hi  = clip_pct(w.range_high);
    ch  = int'(w.motor);
    r.motor_out  = w.motor;
    r.drive_duty = '0;
    if (ch < MOTORS) begin
      if (w.test_mode) begin
        r.drive_duty = duty_t'(tst * 256);
      end else if (req != 0) begin
        q = (curve_on && req != PCT_CAP) ? duty_curve[req] : req * 256;
        num = lo * DUTY_FULL + (hi - lo) * q;
        if (num < 0) num = 0;
        tgt = num / 100;
        if (tgt > DUTY_FULL) tgt = DUTY_FULL;
        delta = tgt - chan_duty[ch];
        if (delta > DUTY_RAMP) delta = DUTY_RAMP;
        if (delta < -DUTY_RAMP) delta = -DUTY_RAMP;
        r.drive_duty = duty_t'(chan_duty[ch] + delta);
      end
      chan_duty[ch] = r.drive_duty;
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin : drv_proc
    logic nv;
    nv = in_valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        duty_expect_q.push_back(predict_duty(in_word));
        words_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!tx_hold && pend_words.size() > 0) begin
          in_word <= pend_words.pop_front();
          nv = 1'b1;
          in_gap = no_idle ? 0 : $urandom_range(0, 9);
        end
      end
    end
    in_valid <= nv;
  end

  // result monitor and output stall
  always @(posedge clk) begin : mon_proc
    out_word_t want;
    logic      ns;
    if (rst_n && out_valid && !out_stall) begin
      if (duty_expect_q.size() == 0) begin
        $error("unexpected word: motor_out %0d drive_duty %0d",
               out_word.motor_out, out_word.drive_duty);
        err_count++;
      end else begin
        want = duty_expect_q.pop_front();
        if (out_word.motor_out !== want.motor_out) begin
          $error("motor_out expected %0d actual %0d", want.motor_out, out_word.motor_out);
          err_count++;
        end
        if (out_word.drive_duty !== want.drive_duty) begin
          $error("drive_duty expected %0d actual %0d", want.drive_duty, out_word.drive_duty);
          err_count++;
        end
        words_checked++;
      end
      out_wait = no_idle ? 0 : $urandom_range(0, 9);
    end
    if (!rst_n || rx_hold) begin
      ns = 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      ns = 1'b1;
    end else begin
      ns = 1'b0;
    end
    out_stall <= ns;
  end

  task automatic add_word(input logic [1:0] m, input logic t, input logic [PCT_W-1:0] req,
                          input logic [PCT_W-1:0] tst, input logic [PCT_W-1:0] lo,
                          input logic [PCT_W-1:0] hi);
    in_word_t w;
    w.motor          = m;
    w.test_mode      = t;
    w.requested_duty = req;
    w.test_duty      = tst;
    w.range_low      = lo;
    w.range_high     = hi;
    pend_words.push_back(w);
  endtask

  function automatic logic [PCT_W-1:0] rand_pct();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return PCT_W'($urandom_range(101, 127));
    if (r < 14) return r[0] ? 7'd0 : 7'd100;
    return PCT_W'($urandom_range(0, 100));
  endfunction

  // mostly steady per-channel setpoints so ramps settle, plus test ticks, stop words and noise
  task automatic queue_random(input int n);
    logic [1:0]  m;
    int unsigned roll;
    for (int i = 0; i < n; i++) begin
      m    = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        add_word(m, 1'b1, rand_pct(), rand_pct(), rand_pct(), rand_pct());
      end else if (roll < 14) begin
        add_word(m, 1'($urandom), 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
      end else if (roll < 17) begin
        add_word(m, 1'b0, 7'd0, rand_pct(), keep_lo[m], keep_hi[m]);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          keep_req[m] = rand_pct();
          keep_lo[m]  = rand_pct();
          keep_hi[m]  = rand_pct();
        end
        add_word(m, 1'b0, keep_req[m], rand_pct(), keep_lo[m], keep_hi[m]);
      end
    end
  endtask

  task automatic wait_drain();
    while (pend_words.size() != 0 || in_valid || duty_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_curve(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    curve_on = v;
    cfg_writes++;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_curve(1'b0);

    // linear path, saturation, stop, test ticks, inverted range
    add_word(2'd0, 1'b0, 7'd100, 7'd0,   7'd0,   7'd100);
    add_word(2'd0, 1'b0, 7'd100, 7'd0,   7'd0,   7'd100);
    add_word(2'd0, 1'b0, 7'd100, 7'd0,   7'd0,   7'd100);
    add_word(2'd0, 1'b0, 7'd0,   7'd0,   7'd0,   7'd100);
    add_word(2'd0, 1'b0, 7'd127, 7'd127, 7'd0,   7'd127);
    add_word(2'd1, 1'b1, 7'd0,   7'd127, 7'd0,   7'd0);
    add_word(2'd1, 1'b1, 7'd50,  7'd0,   7'd100, 7'd100);
    add_word(2'd2, 1'b1, 7'd0,   7'd100, 7'd0,   7'd0);
    add_word(2'd2, 1'b0, 7'd1,   7'd0,   7'd100, 7'd0);
    add_word(2'd3, 1'b0, 7'd50,  7'd0,   7'd127, 7'd127);
    add_word(2'd3, 1'b0, 7'd127, 7'd0,   7'd0,   7'd0);
    add_word(2'd1, 1'b0, 7'd99,  7'd0,   7'd20,  7'd80);
    wait_drain();
    write_curve(1'b1);

    // curve on the ends of its span, full request skips the curve
    add_word(2'd0, 1'b0, 7'd1,   7'd0,   7'd0,   7'd100);
    add_word(2'd0, 1'b0, 7'd99,  7'd0,   7'd0,   7'd100);
    add_word(2'd0, 1'b0, 7'd100, 7'd0,   7'd0,   7'd100);
    add_word(2'd2, 1'b0, 7'd50,  7'd0,   7'd100, 7'd0);
    add_word(2'd1, 1'b1, 7'd30,  7'd64,  7'd0,   7'd100);
    add_word(2'd2, 1'b0, 7'd0,   7'd0,   7'd100, 7'd0);
    add_word(2'd3, 1'b0, 7'd127, 7'd127, 7'd127, 7'd127);
    wait_drain();

    // long output stall while the input side keeps offering words
    queue_random(250);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_LEN) @(posedge clk);
    rx_hold <= 1'b0;
    wait_drain();
    write_curve(1'b0);

    // back to back traffic, then the sender waits for everything to come out
    no_idle <= 1'b1;
    queue_random(250);
    while (pend_words.size() > 120) @(negedge clk);
    @(posedge clk);
    tx_hold <= 1'b1;
    no_idle <= 1'b0;
    while (in_valid || duty_expect_q.size() != 0) @(negedge clk);
    tx_hold <= 1'b0;
    wait_drain();
    write_curve(1'b1);

    queue_random(250);
    wait_drain();

    $display("covered %0d input words and %0d checked results on %0d channels",
             words_sent, words_checked, MOTORS);
    $display("curve register written %0d times, with a long output stall and a sender pause",
             cfg_writes);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
